### sv/hnph_pkg.sv
// shared types, constants and helper functions for the header nonce pow hash core
// no dependencies
package hnph_pkg;

    localparam int HEADER_BYTES = 80;
    localparam int DIGEST_BYTES = 32;
    localparam int SLOT_COUNT   = 9;
    localparam int DIGEST_WORDS = DIGEST_BYTES / 8;
    localparam int MSG_WORDS    = SLOT_COUNT + 1;
    localparam int ROUNDS       = 12;
    // four quarter-mix steps per half round, two half rounds per round
    localparam int NUM_STAGES   = ROUNDS * 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_HASH = 1'b1;

    localparam logic MODE_FIRST = 1'b0;
    localparam logic MODE_LAST  = 1'b1;

    typedef logic [15:0][63:0]          t_state;
    typedef logic [MSG_WORDS-1:0][63:0] t_msg;

    typedef struct packed {
        logic        op;
        logic [3:0]  word_slot;
        logic [63:0] word_value;
        logic [63:0] nonce;
    } t_in;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_number;
        logic [63:0] check_value;
        logic        last;
    } t_out;

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // parameter block word for unkeyed 32-byte digest folded into iv word 0
    localparam logic [63:0] H0_FIRST = IV[0] ^ 64'h0000_0000_0101_0000
                                       ^ 64'(DIGEST_BYTES);

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
        '{4'd14,4'd10,4'd4, 4'd8, 4'd9, 4'd15,4'd13,4'd6,
          4'd1, 4'd12,4'd0, 4'd2, 4'd11,4'd7, 4'd5, 4'd3},
        '{4'd11,4'd8, 4'd12,4'd0, 4'd5, 4'd2, 4'd15,4'd13,
          4'd10,4'd14,4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13,4'd12,4'd11,4'd14,
          4'd2, 4'd6, 4'd5, 4'd10,4'd4, 4'd0, 4'd15,4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10,4'd15,
          4'd14,4'd1, 4'd11,4'd12,4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12,4'd6, 4'd10,4'd0, 4'd11,4'd8, 4'd3,
          4'd4, 4'd13,4'd7, 4'd5, 4'd15,4'd14,4'd1, 4'd9},
        '{4'd12,4'd5, 4'd1, 4'd15,4'd14,4'd13,4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13,4'd11,4'd7, 4'd14,4'd12,4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15,4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15,4'd14,4'd9, 4'd11,4'd3, 4'd0, 4'd8,
          4'd12,4'd2, 4'd13,4'd7, 4'd1, 4'd4, 4'd10,4'd5},
        '{4'd10,4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15,4'd11,4'd9, 4'd14,4'd3, 4'd12,4'd13,4'd0}
    };

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] swap_bytes(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // state word of lane j for role a,b,c,d (0..3); half 1 is the diagonal step
    function automatic logic [3:0] lane_reg(input int half, input int j, input int role);
        return 4'(4*role + ((j + role*half) % 4));
    endfunction

endpackage

### sv/header_nonce_pow_hash_core.sv
// Proof-of-work hash core: nine header words are loaded, then each hash word carries a
// nonce; the header is hashed with one-block BLAKE2b-256 through a chain of 96 quarter-mix
// cells (12 rounds, 8 cells per round), one hash entering per cycle while the chain is not
// stopped. Each hash leaves as four digest words over the single output port; the chain
// stops as a whole while a finished hash waits at its end for the result register.
// Load words are accepted, like hash words, only while the chain is not stopped.
// The check mode is written over the config channel; the user must do so only while idle,
// as the block itself does not enforce it.
module header_nonce_pow_hash_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hnph_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hnph_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_data
);

    localparam int NS = hnph_pkg::NUM_STAGES;

    logic [hnph_pkg::SLOT_COUNT-1:0][63:0] r_store;
    logic                                  r_check_mode;

    logic             w_valid [NS+1];
    hnph_pkg::t_state w_v     [NS+1];
    hnph_pkg::t_msg   w_m     [NS+1];
    logic             w_en;
    logic             w_take;
    logic             w_accept;

    assign w_en       = !w_valid[NS] || w_take;
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= hnph_pkg::MODE_FIRST;
        end else if (i_cfg_valid) begin
            r_check_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
        end else if (w_accept && i_in_data.op == hnph_pkg::OP_LOAD &&
                     i_in_data.word_slot < 4'(hnph_pkg::SLOT_COUNT)) begin
            r_store[i_in_data.word_slot] <= i_in_data.word_value;
        end
    end

    // chain head: initial state and message with the nonce in word four
    always_comb begin
        w_valid[0] = w_accept && i_in_data.op == hnph_pkg::OP_HASH;
        for (int i = 0; i < 8; i++) begin
            w_v[0][i]   = hnph_pkg::IV[i];
            w_v[0][i+8] = hnph_pkg::IV[i];
        end
        w_v[0][0]  = hnph_pkg::H0_FIRST;
        w_v[0][12] = hnph_pkg::IV[4] ^ 64'(hnph_pkg::HEADER_BYTES);
        w_v[0][14] = ~hnph_pkg::IV[6];
        for (int i = 0; i < 4; i++) begin
            w_m[0][i] = r_store[i];
        end
        w_m[0][4] = i_in_data.nonce;
        for (int i = 4; i < hnph_pkg::SLOT_COUNT; i++) begin
            w_m[0][i+1] = r_store[i];
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_cell
        hnph_cell #(.STAGE(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[s]),
            .i_v     (w_v[s]),
            .i_m     (w_m[s]),
            .o_valid (w_valid[s+1]),
            .o_v     (w_v[s+1]),
            .o_m     (w_m[s+1])
        );
    end

    hnph_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NS]),
        .i_v          (w_v[NS]),
        .i_check_mode (r_check_mode),
        .i_out_stall  (i_out_stall),
        .o_take       (w_take),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data)
    );

endmodule

### sv/hnph_cell.sv
// one quarter-mix step of the compression: four lanes side by side, one register stage
// uses hnph_pkg
module hnph_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  hnph_pkg::t_state i_v,
    input  hnph_pkg::t_msg   i_m,
    output logic            o_valid,
    output hnph_pkg::t_state o_v,
    output hnph_pkg::t_msg   o_m
);

    localparam int RND  = STAGE / 8;
    localparam int HALF = (STAGE / 4) % 2;
    localparam int QTR  = STAGE % 4;
    localparam int SROW = RND % 10;

    logic             r_valid;
    hnph_pkg::t_state r_v;
    hnph_pkg::t_msg   r_m;
    hnph_pkg::t_state n_v;

    always_comb begin
        n_v = i_v;
        for (int j = 0; j < 4; j++) begin
            logic [3:0]  ia, ib, ic, id, mi;
            logic [63:0] mw, sum;
            ia  = hnph_pkg::lane_reg(HALF, j, 0);
            ib  = hnph_pkg::lane_reg(HALF, j, 1);
            ic  = hnph_pkg::lane_reg(HALF, j, 2);
            id  = hnph_pkg::lane_reg(HALF, j, 3);
            mi  = hnph_pkg::SIGMA[SROW][2*(4*HALF + j) + QTR/2];
            // message words past the header are zero padding
            mw  = (mi < 4'(hnph_pkg::MSG_WORDS)) ? i_m[mi] : 64'd0;
            sum = 64'd0;
            case (QTR)
                0: begin
                    sum = i_v[ia] + i_v[ib] + mw;
                    n_v[ia] = sum;
                    n_v[id] = hnph_pkg::rotr64(i_v[id] ^ sum, 32);
                end
                1: begin
                    sum = i_v[ic] + i_v[id];
                    n_v[ic] = sum;
                    n_v[ib] = hnph_pkg::rotr64(i_v[ib] ^ sum, 24);
                end
                2: begin
                    sum = i_v[ia] + i_v[ib] + mw;
                    n_v[ia] = sum;
                    n_v[id] = hnph_pkg::rotr64(i_v[id] ^ sum, 16);
                end
                default: begin
                    sum = i_v[ic] + i_v[id];
                    n_v[ic] = sum;
                    n_v[ib] = hnph_pkg::rotr64(i_v[ib] ^ sum, 63);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
            r_m <= i_m;
        end
    end

    assign o_valid = r_valid;
    assign o_v     = r_v;
    assign o_m     = r_m;

endmodule

### sv/hnph_out.sv
// finalization and result register: folds the state into the digest and sends four words
// uses hnph_pkg
module hnph_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hnph_pkg::t_state i_v,
    input  logic             i_check_mode,
    input  logic             i_out_stall,
    output logic             o_take,
    output logic             o_valid,
    output hnph_pkg::t_out   o_data
);

    logic                                 r_valid;
    logic [1:0]                           r_k;
    logic [hnph_pkg::DIGEST_WORDS-1:0][63:0] r_dig;
    logic [63:0]                          r_check;
    logic [hnph_pkg::DIGEST_WORDS-1:0][63:0] n_dig;
    logic                                 w_load;

    assign o_take = !r_valid || (r_k == 2'd3 && !i_out_stall);
    assign w_load = i_valid && o_take;

    always_comb begin
        for (int k = 0; k < hnph_pkg::DIGEST_WORDS; k++) begin
            logic [63:0] h;
            h = (k == 0) ? hnph_pkg::H0_FIRST : hnph_pkg::IV[k];
            n_dig[k] = hnph_pkg::swap_bytes(h ^ i_v[k] ^ i_v[k+8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_k     <= 2'd0;
        end else if (r_valid && !i_out_stall) begin
            if (r_k == 2'd3) begin
                r_valid <= 1'b0;
            end
            r_k <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dig   <= n_dig;
            r_check <= (i_check_mode == hnph_pkg::MODE_LAST) ?
                       n_dig[hnph_pkg::DIGEST_WORDS-1] : n_dig[0];
        end
    end

    assign o_valid             = r_valid;
    assign o_data.digest_word  = r_dig[r_k];
    assign o_data.word_number  = r_k;
    assign o_data.check_value  = r_check;
    assign o_data.last         = (r_k == 2'd3);

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_k != 2'd3 && !i_out_stall |=> r_valid && r_k == $past(r_k) + 2'd1)
        else $error("digest word counter skipped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |=> r_valid && $stable(r_k) && $stable(r_check))
        else $error("result changed while stalled");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_valid && r_k == 2'd0)
        else $error("new hash did not start at word zero");

endmodule

### verif/header_nonce_pow_hash_core_tb.sv
// testbench for the header nonce pow hash core: header loads and nonce hashes with a
// blake2b-256 predictor checked word by word against the output stream
// depends on hnph_pkg and header_nonce_pow_hash_core
module header_nonce_pow_hash_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    hnph_pkg::t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    hnph_pkg::t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    header_nonce_pow_hash_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    localparam logic [63:0] BLAKE_IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    localparam int MSG_ORDER [10][16] = '{
        '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
        '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
        '{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
        '{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
        '{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
        '{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
        '{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
        '{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
        '{6,15,14,9,11,3,0,8,12,2,13,7,1,4,10,5},
        '{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0}
    };
    localparam int MIX_LANES [8][4] = '{
        '{0,4,8,12}, '{1,5,9,13}, '{2,6,10,14}, '{3,7,11,15},
        '{0,5,10,15}, '{1,6,11,12}, '{2,7,8,13}, '{3,4,9,14}
    };

    logic [63:0]    header_words [9];
    logic           check_sel;
    hnph_pkg::t_in  pending_words [$];
    hnph_pkg::t_out expected_digests [$];
    int             mismatch_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] to_big_endian(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
        return r;
    endfunction

    // blake2b-256 of the header with the nonce in place, queues four digest words
    task automatic predict_digest(input logic [63:0] nonce);
        logic [63:0] m [16];
        logic [63:0] h [8];
        logic [63:0] v [16];
        logic [63:0] chk;
        int a, b, c, d, g;
        hnph_pkg::t_out r;
        for (int i = 0; i < 16; i++) m[i] = '0;
        for (int i = 0; i < 4; i++) m[i] = header_words[i];
        m[4] = nonce;
        for (int i = 4; i < 9; i++) m[i+1] = header_words[i];
        for (int i = 0; i < 8; i++) h[i] = BLAKE_IV[i];
        h[0] = h[0] ^ 64'h01010000 ^ 64'd32;
        for (int i = 0; i < 8; i++) begin
            v[i] = h[i];
            v[i+8] = BLAKE_IV[i];
        end
        v[12] = v[12] ^ 64'd80;
        v[14] = ~v[14];
        for (int rnd = 0; rnd < 12; rnd++) begin
            for (g = 0; g < 8; g++) begin
                a = MIX_LANES[g][0]; b = MIX_LANES[g][1];
                c = MIX_LANES[g][2]; d = MIX_LANES[g][3];
                v[a] = v[a] + v[b] + m[MSG_ORDER[rnd % 10][2*g]];
                v[d] = ror(v[d] ^ v[a], 32);
                v[c] = v[c] + v[d];
                v[b] = ror(v[b] ^ v[c], 24);
                v[a] = v[a] + v[b] + m[MSG_ORDER[rnd % 10][2*g+1]];
                v[d] = ror(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];
                v[b] = ror(v[b] ^ v[c], 63);
            end
        end
        for (int i = 0; i < 8; i++) h[i] = h[i] ^ v[i] ^ v[i+8];
        chk = (check_sel == hnph_pkg::MODE_LAST) ? to_big_endian(h[3])
                                                 : to_big_endian(h[0]);
        for (int k = 0; k < 4; k++) begin
            r.digest_word = to_big_endian(h[k]);
            r.word_number = 2'(k);
            r.check_value = chk;
            r.last = (k == 3);
            expected_digests.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_in_valid && o_in_stall)) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // predictor updates on accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_in_data.op == hnph_pkg::OP_HASH) predict_digest(i_in_data.nonce);
            else if (i_in_data.word_slot < 9)
                header_words[i_in_data.word_slot] = i_in_data.word_value;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        hnph_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_digests.size() == 0) begin
                report_mismatch("unexpected word", o_out_data.digest_word, '0);
            end else begin
                want = expected_digests.pop_front();
                if (o_out_data.digest_word !== want.digest_word)
                    report_mismatch("digest_word", o_out_data.digest_word, want.digest_word);
                if (o_out_data.word_number !== want.word_number)
                    report_mismatch("word_number", 64'(o_out_data.word_number),
                                    64'(want.word_number));
                if (o_out_data.check_value !== want.check_value)
                    report_mismatch("check_value", o_out_data.check_value, want.check_value);
                if (o_out_data.last !== want.last)
                    report_mismatch("last", 64'(o_out_data.last), 64'(want.last));
            end
        end
    end

    function automatic hnph_pkg::t_in load_word(input int slot, input logic [63:0] value);
        hnph_pkg::t_in w;
        w.op = hnph_pkg::OP_LOAD;
        w.word_slot = 4'(slot);
        w.word_value = value;
        w.nonce = {$urandom, $urandom};
        return w;
    endfunction

    function automatic hnph_pkg::t_in hash_word(input logic [63:0] nonce);
        hnph_pkg::t_in w;
        w.op = hnph_pkg::OP_HASH;
        w.word_slot = 4'($urandom_range(15));
        w.word_value = {$urandom, $urandom};
        w.nonce = nonce;
        return w;
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_in_valid || expected_digests.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_data <= mode;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        check_sel = mode;
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                // well-formed: a full header refresh then a hash
                0: begin
                    for (int s = 0; s < 9; s++) pending_words.push_back(load_word(s, rand_value()));
                    pending_words.push_back(hash_word(rand_value()));
                end
                1, 2: pending_words.push_back(load_word($urandom_range(8), rand_value()));
                3: pending_words.push_back(load_word($urandom_range(15), rand_value()));
                default: pending_words.push_back(hash_word(rand_value()));
            endcase
        end
    endtask

    initial begin
        for (int i = 0; i < 9; i++) header_words[i] = '0;
        check_sel = hnph_pkg::MODE_FIRST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty header, extreme nonces, every slot, out-of-range slots
        send_idle_pct = 6; recv_idle_pct = 75;
        pending_words.push_back(hash_word('0));
        pending_words.push_back(hash_word('1));
        for (int s = 0; s < 9; s++) pending_words.push_back(load_word(s, '1));
        pending_words.push_back(hash_word('0));
        pending_words.push_back(load_word(9, '0));
        pending_words.push_back(load_word(15, '0));
        pending_words.push_back(hash_word(64'h0123456789abcdef));
        for (int s = 0; s < 9; s++) pending_words.push_back(load_word(s, {$urandom, $urandom}));
        pending_words.push_back(hash_word({$urandom, $urandom}));
        wait_drained();

        write_mode(hnph_pkg::MODE_LAST);
        pending_words.push_back(hash_word('1));
        queue_random(78);
        wait_drained();

        send_idle_pct = 75; recv_idle_pct = 6;
        write_mode(hnph_pkg::MODE_FIRST);
        queue_random(78);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_mode(hnph_pkg::MODE_LAST);
        queue_random(78);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("[header_nonce_pow_hash_core] OK");
        end else begin
            $display("[header_nonce_pow_hash_core] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[header_nonce_pow_hash_core] ERROR");
        $finish;
    end
endmodule

### sim.f
sv/hnph_pkg.sv
sv/hnph_cell.sv
sv/hnph_out.sv
sv/header_nonce_pow_hash_core.sv
verif/header_nonce_pow_hash_core_tb.sv
